FILE: hdl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define ALE_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ale_pkg.sv
`default_nettype none
package ale_pkg;

    localparam int ALE_IMM_BITS   = 20;
    localparam int ALE_REG_COUNT  = 8;
    localparam int ALE_TEXT_CHARS = 7;
    localparam int ALE_TEXT_BITS  = 8 * ALE_TEXT_CHARS;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_HALT    = 3'd1;
    localparam logic [2:0] KIND_SYSCALL = 3'd2;
    localparam logic [2:0] KIND_MOVI    = 3'd3;
    localparam logic [2:0] KIND_CMP     = 3'd4;
    localparam logic [2:0] KIND_JUMP    = 3'd5;
    localparam logic [2:0] KIND_JZ      = 3'd6;
    localparam logic [2:0] KIND_JNZ     = 3'd7;

    localparam logic [31:0] WORD_HALT    = 32'h0100_0000;
    localparam logic [31:0] WORD_SYSCALL = 32'h6000_0000;
    localparam logic [31:0] WORD_MOVI    = 32'h4000_0000;
    localparam logic [31:0] WORD_CMP     = 32'h2400_0000;
    localparam logic [31:0] WORD_JUMP    = 32'h6800_0000;
    localparam logic [31:0] WORD_JZ      = 32'h6A00_0000;
    localparam logic [31:0] WORD_JNZ     = 32'h6B00_0000;

    // Mnemonic text, first character in the low byte.
    localparam logic [ALE_TEXT_BITS-1:0] NAME_HALT    = 56'h0000_0054_4C41_48;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_SYSCALL = 56'h4C4C_4143_5359_53;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_MOVI    = 56'h0000_0049_564F_4D;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_CMP     = 56'h0000_0000_504D_43;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_JUMP    = 56'h0000_0050_4D55_4A;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_JZ      = 56'h0000_0000_005A_4A;
    localparam logic [ALE_TEXT_BITS-1:0] NAME_JNZ     = 56'h0000_0000_5A4E_4A;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } ale_req_t;

    typedef struct packed {
        logic        emit;
        logic [31:0] instruction_word;
        logic        status;
    } ale_res_t;

    function automatic logic [2:0] ale_mnemonic(input logic [ALE_TEXT_BITS-1:0] text,
                                                 input logic [3:0] len);
        logic [2:0] kind;
        kind = KIND_NONE;
        if (len == 4'd4 && text == NAME_HALT) kind = KIND_HALT;
        if (len == 4'd7 && text == NAME_SYSCALL) kind = KIND_SYSCALL;
        if (len == 4'd4 && text == NAME_MOVI) kind = KIND_MOVI;
        if (len == 4'd3 && text == NAME_CMP) kind = KIND_CMP;
        if (len == 4'd4 && text == NAME_JUMP) kind = KIND_JUMP;
        if (len == 4'd2 && text == NAME_JZ) kind = KIND_JZ;
        if (len == 4'd3 && text == NAME_JNZ) kind = KIND_JNZ;
        return kind;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ale_parser.sv
`default_nettype none
module ale_parser
    import ale_pkg::*;
#(
    parameter int IMM_BITS  = ALE_IMM_BITS,
    parameter int REG_COUNT = ALE_REG_COUNT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire ale_req_t req,
    output ale_res_t      res
);

    localparam int RegW = (REG_COUNT > 2) ? $clog2(REG_COUNT) : 1;
    localparam int AccW = IMM_BITS + 5;
    localparam logic [IMM_BITS-1:0] ImmMax = '1;
    localparam logic [7:0] RegLimit = 8'(8'h30 + REG_COUNT);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_X     = 8'h58;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEXPFX = 3'd3;
    localparam logic [2:0] PH_DEC    = 3'd4;
    localparam logic [2:0] PH_OCT    = 3'd5;
    localparam logic [2:0] PH_HEX    = 3'd6;
    localparam logic [2:0] PH_BAD    = 3'd7;

    typedef struct packed {
        logic                     in_comment;
        logic [2:0]               pos;
        logic                     in_token;
        logic [ALE_TEXT_BITS-1:0] text;
        logic [3:0]               len;
        logic [2:0]               kind;
        logic [IMM_BITS-1:0]      acc;
        logic [2:0]               phase;
        logic                     neg;
        logic                     ovf;
        logic [RegW-1:0]          reg1;
        logic [RegW-1:0]          reg2;
        logic [IMM_BITS-1:0]      imm;
        logic                     err;
        logic                     lead_vf;
        logic                     vf_after;
        logic                     dirty;
    } st_t;

    st_t state_reg, state_next, fin;

    logic [7:0]          uc;
    logic                dv;
    logic [3:0]          dval;
    logic                num_ok, reg_ok, tok_ok;
    logic [RegW-1:0]     reg_val;
    logic [2:0]          mn_kind;
    logic [AccW-1:0]     acc_ext, prod, sum;
    logic                emit_line, bad_line;
    logic [2:0]          need;
    logic [31:0]         word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        uc = req.char_code;
        if (req.char_code inside {[8'h61:8'h7A]}) begin
            uc = req.char_code - 8'h20;
        end
        dv   = 1'b0;
        dval = 4'd0;
        if (uc inside {[8'h30:8'h39]}) begin
            dv   = 1'b1;
            dval = 4'(uc - 8'h30);
        end else if (uc inside {[8'h41:8'h46]}) begin
            dv   = 1'b1;
            dval = 4'(uc - 8'h37);
        end
    end

    assign mn_kind = ale_mnemonic(state_reg.text, state_reg.len);
    assign num_ok  = (state_reg.phase inside {PH_ZERO, PH_DEC, PH_OCT, PH_HEX}) &&
                     !state_reg.ovf && !(state_reg.neg && state_reg.acc != '0);
    assign reg_ok  = !state_reg.lead_vf && state_reg.len == 4'd2 &&
                     state_reg.text[7:0] == CH_R &&
                     state_reg.text[15:8] >= CH_ZERO && state_reg.text[15:8] < RegLimit;
    assign reg_val = RegW'(state_reg.text[15:8] - CH_ZERO);

    // Close the current token.
    always_comb begin
        fin    = state_reg;
        tok_ok = 1'b0;
        if (state_reg.in_token) begin
            if (state_reg.len == 4'd0) begin
                if (state_reg.pos != 3'd0) fin.dirty = 1'b1;
            end else begin
                if (state_reg.vf_after) fin.dirty = 1'b1;
                case (state_reg.pos)
                    3'd0: begin
                        fin.kind = mn_kind;
                        tok_ok   = mn_kind != KIND_NONE;
                    end
                    3'd1: begin
                        if (state_reg.kind inside {KIND_SYSCALL, KIND_JUMP, KIND_JZ, KIND_JNZ}) begin
                            tok_ok = num_ok;
                            if (num_ok) fin.imm = state_reg.acc;
                        end else if (state_reg.kind inside {KIND_MOVI, KIND_CMP}) begin
                            tok_ok = reg_ok;
                            if (reg_ok) fin.reg1 = reg_val;
                        end
                    end
                    3'd2: begin
                        if (state_reg.kind == KIND_MOVI) begin
                            tok_ok = num_ok;
                            if (num_ok) fin.imm = state_reg.acc;
                        end else if (state_reg.kind == KIND_CMP) begin
                            tok_ok = reg_ok;
                            if (reg_ok) fin.reg2 = reg_val;
                        end
                    end
                    default: tok_ok = 1'b0;
                endcase
                if (!tok_ok) fin.err = 1'b1;
                if (state_reg.pos != 3'd7) fin.pos = state_reg.pos + 3'd1;
            end
            fin.in_token = 1'b0;
            fin.text     = '0;
            fin.len      = 4'd0;
            fin.acc      = '0;
            fin.phase    = PH_START;
            fin.neg      = 1'b0;
            fin.ovf      = 1'b0;
            fin.lead_vf  = 1'b0;
            fin.vf_after = 1'b0;
        end
    end

    // Line result from the closed state.
    always_comb begin
        emit_line = fin.pos != 3'd0;
        case (fin.kind)
            KIND_HALT:             need = 3'd1;
            KIND_MOVI, KIND_CMP:   need = 3'd3;
            default:               need = 3'd2;
        endcase
        bad_line = fin.err || fin.kind == KIND_NONE || fin.pos < need;
        case (fin.kind)
            KIND_HALT:    word = WORD_HALT;
            KIND_SYSCALL: word = WORD_SYSCALL | 32'(fin.imm);
            KIND_MOVI:    word = WORD_MOVI | (32'(fin.reg1) << IMM_BITS) | 32'(fin.imm);
            KIND_CMP:     word = WORD_CMP | (32'(fin.reg1) << 20) | (32'(fin.reg2) << 16);
            KIND_JUMP:    word = WORD_JUMP | 32'(fin.imm);
            KIND_JZ:      word = WORD_JZ | 32'(fin.imm);
            KIND_JNZ:     word = WORD_JNZ | 32'(fin.imm);
            default:      word = '0;
        endcase
    end

    // Accumulator step for the digit bases.
    always_comb begin
        acc_ext = AccW'(state_reg.acc);
        case (state_reg.phase)
            PH_DEC:  prod = (acc_ext << 3) + (acc_ext << 1);
            PH_OCT:  prod = acc_ext << 3;
            default: prod = acc_ext << 4;
        endcase
        sum = prod + AccW'(dval);
    end

    always_comb begin
        state_next           = state_reg;
        res.emit             = 1'b0;
        res.instruction_word = '0;
        res.status           = 1'b0;
        if (step) begin
            if (req.end_of_text || req.char_code == CH_LF) begin
                res.emit             = emit_line;
                res.status           = bad_line;
                res.instruction_word = bad_line ? 32'd0 : word;
                state_next           = '0;
            end else if (state_reg.in_comment) begin
                state_next = state_reg;
            end else if (req.char_code inside {CH_SEMI, CH_HASH, CH_NUL}) begin
                state_next            = fin;
                state_next.in_comment = 1'b1;
            end else if (req.char_code inside {CH_SPACE, CH_TAB, CH_CR, CH_COMMA}) begin
                state_next = fin;
            end else begin
                state_next.in_token = 1'b1;
                if (req.char_code inside {CH_VT, CH_FF}) begin
                    if (state_reg.len == 4'd0) begin
                        state_next.lead_vf = 1'b1;
                    end else begin
                        state_next.vf_after = 1'b1;
                    end
                end else begin
                    if (state_reg.len == 4'd0 && state_reg.dirty) state_next.err = 1'b1;
                    if (state_reg.vf_after) state_next.err = 1'b1;
                    if (state_reg.len < 4'(ALE_TEXT_CHARS)) begin
                        state_next.text[state_reg.len[2:0]*8 +: 8] = uc;
                    end
                    if (state_reg.len < 4'd9) state_next.len = state_reg.len + 4'd1;
                    case (state_reg.phase)
                        PH_START, PH_SIGN: begin
                            if (state_reg.phase == PH_START && (uc == CH_PLUS || uc == CH_MINUS)) begin
                                if (uc == CH_MINUS) state_next.neg = 1'b1;
                                state_next.phase = PH_SIGN;
                            end else if (uc == CH_ZERO) begin
                                state_next.phase = PH_ZERO;
                            end else if (dv && dval <= 4'd9) begin
                                state_next.acc   = IMM_BITS'(dval);
                                state_next.phase = PH_DEC;
                            end else begin
                                state_next.phase = PH_BAD;
                            end
                        end
                        PH_ZERO: begin
                            if (uc == CH_X) begin
                                state_next.phase = PH_HEXPFX;
                            end else if (dv && dval <= 4'd7) begin
                                state_next.acc   = IMM_BITS'(dval);
                                state_next.phase = PH_OCT;
                            end else begin
                                state_next.phase = PH_BAD;
                            end
                        end
                        PH_HEXPFX: begin
                            if (dv) begin
                                state_next.acc   = IMM_BITS'(dval);
                                state_next.phase = PH_HEX;
                            end else begin
                                state_next.phase = PH_BAD;
                            end
                        end
                        PH_DEC, PH_OCT, PH_HEX: begin
                            if ((state_reg.phase == PH_DEC && dv && dval <= 4'd9) ||
                                (state_reg.phase == PH_OCT && dv && dval <= 4'd7) ||
                                (state_reg.phase == PH_HEX && dv)) begin
                                if (sum > AccW'(ImmMax)) begin
                                    state_next.ovf = 1'b1;
                                    state_next.acc = ImmMax;
                                end else begin
                                    state_next.acc = sum[IMM_BITS-1:0];
                                end
                            end else begin
                                state_next.phase = PH_BAD;
                            end
                        end
                        default: state_next.phase = PH_BAD;
                    endcase
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/assembly_line_encoder_core.sv
// The closing character is held in the input register and its result in the result register.
// Throughput: one character per cycle, parsed in a single pass, unless a held result stalls.
// Input register, one-pass parse update and result register let both sides stall freely.
// Reset (aresetn low, synchronous) clears the parse state and both pipeline valid flags.
`default_nettype none
module assembly_line_encoder_core
    import ale_pkg::*;
#(
    parameter int IMM_BITS  = ALE_IMM_BITS,
    parameter int REG_COUNT = ALE_REG_COUNT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_instruction_word,
    output logic             m_status
);

    logic      in_valid_reg, in_valid_next;
    ale_req_t  in_req_reg;
    logic      out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg;
    logic      out_status_reg;
    logic      advance;
    ale_res_t  res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && res.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.char_code   <= s_char_code;
            in_req_reg.end_of_text <= s_end_of_text;
        end
        if (advance && res.emit) begin
            out_word_reg   <= res.instruction_word;
            out_status_reg <= res.status;
        end
    end

    ale_parser #(
        .IMM_BITS  (IMM_BITS),
        .REG_COUNT (REG_COUNT)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (in_req_reg),
        .res     (res)
    );

    assign m_valid            = out_valid_reg;
    assign m_instruction_word = out_word_reg;
    assign m_status           = out_status_reg;

endmodule
`default_nettype wire

FILE: hdl/ale_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ale_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_char_code,
    input wire logic        s_end_of_text,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_instruction_word,
    input wire logic        m_status
);

    `ALE_ASSERT_NOW(a_err_word_zero, m_valid && m_status, m_instruction_word == 32'd0, "invalid line carries a nonzero word")
    `ALE_ASSERT_NOW(a_ok_word_nonzero, m_valid && !m_status, m_instruction_word != 32'd0, "valid line carries a zero word")
    `ALE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_instruction_word) && $stable(m_status), "stalled request changed")
    `ALE_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_char_code) && $stable(s_end_of_text), "waiting request changed")
    `ALE_ASSERT_NEXT_ALWAYS(a_reset_clear, !aresetn, !m_valid && s_ready, "reset left a request pending")

endmodule

bind assembly_line_encoder_core ale_checker u_ale_checker (.*);
`default_nettype wire

FILE: test/assembly_line_encoder_core_tb.sv
`timescale 1ns / 1ps
module assembly_line_encoder_core_tb;
    import ale_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_CHARS = 1570;
    localparam longint IMM_LIMIT = (64'd1 << ALE_IMM_BITS) - 1;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_SIGN  = 3'd1;
    localparam logic [2:0] PH_ZERO  = 3'd2;
    localparam logic [2:0] PH_HEX0  = 3'd3;
    localparam logic [2:0] PH_DEC   = 3'd4;
    localparam logic [2:0] PH_OCT   = 3'd5;
    localparam logic [2:0] PH_HEX   = 3'd6;
    localparam logic [2:0] PH_BAD   = 3'd7;

    localparam logic [31:0] OPW_HALT    = 32'h0100_0000;
    localparam logic [31:0] OPW_SYSCALL = 32'h6000_0000;
    localparam logic [31:0] OPW_MOVI    = 32'h4000_0000;
    localparam logic [31:0] OPW_CMP     = 32'h2400_0000;
    localparam logic [31:0] OPW_JUMP    = 32'h6800_0000;
    localparam logic [31:0] OPW_JZ      = 32'h6A00_0000;
    localparam logic [31:0] OPW_JNZ     = 32'h6B00_0000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       hold;
    } char_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_instruction_word;
    logic        m_status;

    char_req_t   pend[$];
    logic [32:0] words_due[$];
    logic        hold_next = 1'b0;
    logic        req_taken = 1'b0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          chars_in = 0;
    int          encoded = 0;
    int          rejected = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_cnt = 0;
    int          stall_phase = 0;

    logic        cmt_on, tok_open, vf_lead, vf_trail, gap_dirty, line_bad;
    logic [2:0]  tok_pos, op_kind, num_ph, reg_a, reg_b;
    logic [3:0]  tok_len;
    logic [63:0] tok_text;
    logic [1:0]  num_fl;
    logic [31:0] num_acc, imm_val;

    assembly_line_encoder_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .s_end_of_text      (s_end_of_text),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_instruction_word (m_instruction_word),
        .m_status           (m_status)
    );

    always #5 aclk = ~aclk;

    task automatic drop_token();
        tok_open = 1'b0;
        tok_text = '0;
        tok_len = '0;
        num_acc = '0;
        num_ph = PH_START;
        num_fl = '0;
        vf_lead = 1'b0;
        vf_trail = 1'b0;
    endtask

    task automatic drop_line();
        cmt_on = 1'b0;
        tok_pos = '0;
        op_kind = KIND_NONE;
        reg_a = '0;
        reg_b = '0;
        imm_val = '0;
        line_bad = 1'b0;
        gap_dirty = 1'b0;
        drop_token();
    endtask

    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic feed_number(input logic [7:0] c);
        int d;
        int base;
        longint v;
        d = digit_of(c);
        base = 0;
        if (num_ph == PH_START || num_ph == PH_SIGN) begin
            if (num_ph == PH_START && (c == "+" || c == "-")) begin
                if (c == "-") num_fl[0] = 1'b1;
                num_ph = PH_SIGN;
            end else if (c == "0") begin
                num_ph = PH_ZERO;
            end else if (d >= 1 && d <= 9) begin
                num_acc = d;
                num_ph = PH_DEC;
            end else begin
                num_ph = PH_BAD;
            end
        end else if (num_ph == PH_ZERO) begin
            if (c == "X") begin
                num_ph = PH_HEX0;
            end else if (d >= 0 && d <= 7) begin
                num_acc = d;
                num_ph = PH_OCT;
            end else begin
                num_ph = PH_BAD;
            end
        end else if (num_ph == PH_HEX0) begin
            if (d >= 0) begin
                num_acc = d;
                num_ph = PH_HEX;
            end else begin
                num_ph = PH_BAD;
            end
        end else begin
            if (num_ph == PH_DEC && d >= 0 && d <= 9) base = 10;
            else if (num_ph == PH_OCT && d >= 0 && d <= 7) base = 8;
            else if (num_ph == PH_HEX && d >= 0) base = 16;
            if (base == 0) begin
                num_ph = PH_BAD;
            end else begin
                v = longint'(num_acc) * base + d;
                if (v > IMM_LIMIT) begin
                    num_fl[1] = 1'b1;
                    v = IMM_LIMIT;
                end
                num_acc = v[31:0];
            end
        end
    endtask

    task automatic take_number(output logic ok);
        ok = (num_ph == PH_ZERO || num_ph == PH_DEC || num_ph == PH_OCT || num_ph == PH_HEX)
             && !num_fl[1] && !(num_fl[0] && num_acc != 0);
        if (ok) imm_val = num_acc;
    endtask

    task automatic take_register(output logic ok, output logic [2:0] r);
        logic [7:0] c0;
        logic [7:0] c1;
        c0 = tok_text[15:8];
        c1 = tok_text[7:0];
        ok = !vf_lead && tok_len == 4'd2 && c0 == "R" && c1 >= "0"
             && int'(c1) < int'("0") + ALE_REG_COUNT;
        r = c1[2:0];
    endtask

    task automatic close_token();
        logic ok;
        logic [2:0] r;
        ok = 1'b0;
        if (tok_open) begin
            if (tok_len == 0) begin
                if (tok_pos > 0) gap_dirty = 1'b1;
            end else begin
                if (vf_trail) gap_dirty = 1'b1;
                if (tok_pos == 0) begin
                    if (tok_text == "HALT") op_kind = KIND_HALT;
                    else if (tok_text == "SYSCALL") op_kind = KIND_SYSCALL;
                    else if (tok_text == "MOVI") op_kind = KIND_MOVI;
                    else if (tok_text == "CMP") op_kind = KIND_CMP;
                    else if (tok_text == "JUMP") op_kind = KIND_JUMP;
                    else if (tok_text == "JZ") op_kind = KIND_JZ;
                    else if (tok_text == "JNZ") op_kind = KIND_JNZ;
                    ok = (op_kind != KIND_NONE);
                end else if (tok_pos == 1) begin
                    if (op_kind == KIND_SYSCALL || op_kind >= KIND_JUMP) begin
                        take_number(ok);
                    end else if (op_kind == KIND_MOVI || op_kind == KIND_CMP) begin
                        take_register(ok, r);
                        if (ok) reg_a = r;
                    end
                end else if (tok_pos == 2) begin
                    if (op_kind == KIND_MOVI) begin
                        take_number(ok);
                    end else if (op_kind == KIND_CMP) begin
                        take_register(ok, r);
                        if (ok) reg_b = r;
                    end
                end
                if (!ok) line_bad = 1'b1;
                if (tok_pos < 7) tok_pos++;
            end
            drop_token();
        end
    endtask

    task automatic close_line(output logic has, output logic [31:0] word, output logic st);
        int need;
        close_token();
        has = 1'b0;
        word = '0;
        st = 1'b0;
        if (tok_pos != 0) begin
            has = 1'b1;
            need = (op_kind == KIND_HALT) ? 1 : (op_kind == KIND_MOVI || op_kind == KIND_CMP) ? 3 : 2;
            if (line_bad || op_kind == KIND_NONE || tok_pos < need) begin
                st = 1'b1;
            end else begin
                case (op_kind)
                    KIND_HALT:    word = OPW_HALT;
                    KIND_SYSCALL: word = OPW_SYSCALL | imm_val;
                    KIND_MOVI:    word = OPW_MOVI | (32'(reg_a) << ALE_IMM_BITS) | imm_val;
                    KIND_CMP:     word = OPW_CMP | (32'(reg_a) << 20) | (32'(reg_b) << 16);
                    KIND_JUMP:    word = OPW_JUMP | imm_val;
                    KIND_JZ:      word = OPW_JZ | imm_val;
                    default:      word = OPW_JNZ | imm_val;
                endcase
            end
        end
        drop_line();
    endtask

    task automatic assemble_char(input logic [7:0] ch, input logic eot, output logic has,
                                 output logic [31:0] word, output logic st);
        logic [7:0] c;
        has = 1'b0;
        word = '0;
        st = 1'b0;
        c = ch;
        if (eot || c == CH_LF) begin
            close_line(has, word, st);
        end else if (!cmt_on) begin
            if (c == ";" || c == "#" || c == CH_NUL) begin
                close_token();
                cmt_on = 1'b1;
            end else if (c == " " || c == CH_TAB || c == CH_CR || c == ",") begin
                close_token();
            end else begin
                tok_open = 1'b1;
                if (c == CH_VT || c == CH_FF) begin
                    if (tok_len == 0) vf_lead = 1'b1;
                    else vf_trail = 1'b1;
                end else begin
                    if (c >= "a" && c <= "z") c = c - 8'd32;
                    if (tok_len == 0 && gap_dirty) line_bad = 1'b1;
                    if (vf_trail) line_bad = 1'b1;
                    if (tok_len < 8) tok_text = {tok_text[55:0], c};
                    if (tok_len < 9) tok_len++;
                    feed_number(c);
                end
            end
        end
    endtask

    task automatic put_char(input logic [7:0] c, input logic eot);
        char_req_t r;
        r.ch = c;
        r.eot = eot;
        r.hold = hold_next;
        hold_next = 1'b0;
        pend.push_back(r);
    endtask

    task automatic put_text(input string s);
        int i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 3) == 0)
                c = c ^ 8'h20;
            put_char(c, 1'b0);
        end
    endtask

    task automatic put_gap();
        case ($urandom_range(0, 5))
            0: put_char(" ", 1'b0);
            1: put_char(CH_TAB, 1'b0);
            2: put_char(",", 1'b0);
            3: put_text(" , ");
            4: put_text(",  ");
            default: begin
                put_char(CH_CR, 1'b0);
                put_char(" ", 1'b0);
            end
        endcase
    endtask

    task automatic put_vf();
        put_char(($urandom_range(0, 1) != 0) ? CH_VT : CH_FF, 1'b0);
    endtask

    task automatic put_reg();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) put_text($sformatf("R%0d", $urandom_range(0, 7)));
        else if (sel < 88) put_text($sformatf("R%0d", $urandom_range(8, 9)));
        else if (sel < 92) put_text("R");
        else if (sel < 96) put_text($sformatf("R%0d", $urandom_range(10, 99)));
        else begin
            put_vf();
            put_text("R2");
        end
    endtask

    task automatic put_imm();
        logic [31:0] v;
        int sel;
        string txt;
        if ($urandom_range(0, 9) == 0) put_vf();
        sel = $urandom_range(0, 99);
        if (sel < 15) v = 0;
        else if (sel < 50) v = $urandom_range(1, 255);
        else if (sel < 70) v = $urandom_range(32'h000F_FFF0, 32'h0010_000F);
        else if (sel < 90) v = $urandom_range(0, 32'h001F_FFFF);
        else v = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 6 || (v == 0 && sel < 40)) put_char("-", 1'b0);
        else if (sel < 52) put_char("+", 1'b0);
        case ($urandom_range(0, 3))
            0: txt = $sformatf("%0d", v);
            1: txt = $sformatf("0x%0h", v);
            2: txt = $sformatf("0X%06h", v);
            default: txt = $sformatf("0%0o", v);
        endcase
        put_text(txt);
    endtask

    task automatic add_random_line();
        int pick, kind, nops, i, sel;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            kind = $urandom_range(0, 6);
            if ($urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 1) != 0) put_gap();
                else put_vf();
            end
            case (kind)
                0: put_text("HALT");
                1: put_text("SYSCALL");
                2: put_text("MOVI");
                3: put_text("CMP");
                4: put_text("JUMP");
                5: put_text("JZ");
                default: put_text("JNZ");
            endcase
            nops = (kind == 0) ? 0 : (kind == 2 || kind == 3) ? 2 : 1;
            if ($urandom_range(0, 9) == 0) nops++;
            else if ($urandom_range(0, 14) == 0 && nops > 0) nops--;
            for (i = 0; i < nops; i++) begin
                put_gap();
                if ((kind == 2 && i == 0) || (kind == 3 && i < 2)) put_reg();
                else put_imm();
            end
        end else if (pick < 86) begin
            nops = $urandom_range(1, 12);
            for (i = 0; i < nops; i++) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) put_char(8'($urandom_range(0, 255)), 1'b0);
                else if (sel < 8) put_char(8'($urandom_range(33, 126)), 1'b0);
                else put_gap();
            end
        end else begin
            case ($urandom_range(0, 7))
                0: put_text("JUMP 0x");
                1: put_text("JZ -");
                2: put_text("JNZ 08");
                3: put_text("SYSCALL +-1");
                4: put_text("MOVI R1, -7");
                5: put_text("JUMP 0x1G");
                6: begin
                    put_text("J");
                    put_vf();
                    put_text("Z 4");
                end
                default: begin
                    put_text("CMP R1 ");
                    put_vf();
                    put_text(" R2");
                end
            endcase
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) put_text(" ; note");
        else if (sel < 14) put_text(" #x 1");
        else if (sel < 17) begin
            put_char(CH_NUL, 1'b0);
            put_text("R9 zz");
        end else if (sel < 20) put_vf();
        else if (sel < 25) put_gap();
        sel = $urandom_range(0, 99);
        if (sel < 6) put_char(8'($urandom_range(0, 255)), 1'b1);
        else if (sel < 9) begin
            put_char(CH_CR, 1'b0);
            put_char(CH_LF, 1'b0);
        end else put_char(CH_LF, 1'b0);
    endtask

    always @(negedge aclk) begin : drive
        char_req_t nxt;
        logic go;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pend.size() > 0) begin
                nxt = pend[0];
                go = !nxt.hold || words_due.size() == 0;
            end
            if (go) begin
                nxt = pend.pop_front();
                s_char_code <= nxt.ch;
                s_end_of_text <= nxt.eot;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 5) == 0) begin
                    burst_left = $urandom_range(100, 300);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt = $urandom_range(50, 300);
        end else begin
            stall_cnt--;
        end
        stall_phase++;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) != 0);
            2: m_ready <= (stall_phase % 4 == 0);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin : watch
        logic [32:0] want;
        logic has;
        logic [31:0] w;
        logic st;
        logic moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (m_status) rejected++;
                else encoded++;
                if (words_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: word %h status %b",
                                 m_instruction_word, m_status);
                end else begin
                    want = words_due.pop_front();
                    if (m_instruction_word !== want[32:1] || m_status !== want[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: word exp %h got %h, status exp %b got %b",
                                     want[32:1], m_instruction_word, want[0], m_status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                req_taken = 1'b1;
                chars_in++;
                assemble_char(s_char_code, s_end_of_text, has, w, st);
                if (has) words_due.push_back({w, st});
            end
            if (moved) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request or result for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stim
        int base_count;
        int lines;
        drop_line();

        put_text("HALT\n");
        put_text("syscall 0xFFFFF\n");
        put_text("MOVI R7, 1048575\n");
        put_text("cmp r0,r7\n");
        put_text("JUMP 0\n");
        put_text("jz 017777\n");
        put_text("JNZ +12 ; trailing note\n");
        put_text("JUMP -0\n");
        put_text("JUMP -5\n");
        put_text("SYSCALL 0x100000\n");
        put_text("JZ 0x\n");
        put_text("JNZ 09\n");
        put_text("JUMP +\n");
        put_text("MOVI R8, 1\n");
        put_text("CMP R1\n");
        put_text("HALT R1\n");
        put_text("FETCH 3\n");
        put_text("\n");
        put_text("   ; nothing here\n");
        put_char(CH_TAB, 1'b0);
        put_char(CH_CR, 1'b0);
        put_text(",#HALT\n");
        put_char(CH_VT, 1'b0);
        put_text("HALT");
        put_char(CH_FF, 1'b0);
        put_text("\n");
        put_text("JUMP ");
        put_char(CH_VT, 1'b0);
        put_char(CH_FF, 1'b0);
        put_text("12\n");
        put_text("HA");
        put_char(CH_VT, 1'b0);
        put_text("LT\n");
        put_text("CMP R1, ");
        put_char(CH_FF, 1'b0);
        put_text(" , R2\n");
        put_text("JUMP 5 ");
        put_char(CH_VT, 1'b0);
        put_text("\n");
        hold_next = 1'b1;
        put_text("HALT");
        put_char(8'hA5, 1'b1);
        put_char(CH_LF, 1'b1);
        put_text("MOVI");
        put_char(CH_TAB, 1'b0);
        put_text("R3,");
        put_char(CH_CR, 1'b0);
        put_text("0x1F");
        put_char(CH_NUL, 1'b0);
        put_text("junk\n");
        put_text("MOVI R1, 0000000000000000000000012\n");
        put_text("jnz 0Xabcde\n");
        put_text("HALT");
        put_char(8'hFF, 1'b0);
        put_char(8'h80, 1'b0);
        put_text("\n");

        base_count = pend.size();
        lines = 0;
        while (pend.size() < base_count + RANDOM_CHARS) begin
            lines++;
            if (lines % 20 == 0) hold_next = 1'b1;
            add_random_line();
        end
        put_char(8'h00, 1'b1);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pend.size() != 0 || s_valid) @(posedge aclk);
        while (words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run covered %0d characters: %0d lines encoded, %0d lines rejected, %0d mismatches",
                 chars_in, encoded, rejected, mismatches);
        if (mismatches == 0 && words_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
